// ----- design/adcfce_pkg.sv -----
`default_nettype none

package adcfce_pkg;

    // frame parser phases
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    localparam logic [31:0] SYNC_WORD      = 32'hFFFF_FFFF;
    localparam int          WORD_W         = 32;
    localparam int          SAMPLE_W       = 24;
    localparam int          CHAN_W         = 8;
    localparam logic [7:0]  CHAN_ID_RESET  = 8'hEA;

endpackage : adcfce_pkg

`default_nettype wire

// ----- design/adc_frame_channel_extractor.sv -----
`default_nettype none

// ADC frame channel extractor
// Takes one 32-bit record word per transaction on the s_ stream channel,
// hunts for the sync word (all ones), skips the header word, reads the
// frame length in bytes and then walks floor(length/4) payload words.
// Payload words whose top byte equals the channel id give out their low
// 24 bits as a signed sample on the m_ stream channel. Frames with the
// header top bit set, or a length above MAX_FRAME_BYTES or below four,
// are dropped and the parser goes back to hunting.
// The channel id is written through the cfg_ channel; it is always ready
// and should only be changed while no words are in flight.
// Throughput is one word per cycle while the receiver keeps up: the parse
// step is a compare and a counter update between the input register and
// the result register, and a word passes through both on the way to its sample.
// When the receiver stalls, the result register holds and the input
// register fills, after which s_tready drops until a sample is taken.
// Reset clears both registers, returns the parser to hunting with no
// payload words pending and sets the channel id to 0xEA.
module adc_frame_channel_extractor
    import adcfce_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1500
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [WORD_W-1:0]          s_tdata,   // [31:0] stream_word
    // output stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic signed [SAMPLE_W-1:0]      m_tdata,   // [23:0] sample
    // configuration
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CHAN_W-1:0]          cfg_data   // [7:0] channel_id
);

    localparam int MAX_WORDS = MAX_FRAME_BYTES / 4;
    localparam int WL_W      = $clog2(MAX_WORDS + 1);

    logic                    in_valid_reg;
    logic [WORD_W-1:0]       in_word_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_W-1:0]     out_sample_reg;
    logic [CHAN_W-1:0]       chan_id_reg;
    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [WL_W-1:0]         words_left_reg;
    logic [WL_W-1:0]         words_left_next;
    logic [WL_W-1:0]         words_dec;
    logic                    out_free;
    logic                    advance;
    logic                    len_ok;
    logic                    chan_match;
    logic                    hit;

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = signed'(out_sample_reg);

    // decode of the word in the input register
    assign len_ok     = (in_word_reg <= WORD_W'(MAX_FRAME_BYTES))
                        && (in_word_reg[WORD_W-1:2] != '0);
    assign chan_match = (in_word_reg[WORD_W-1:SAMPLE_W] == chan_id_reg);
    assign words_dec  = (words_left_reg != '0) ? words_left_reg - WL_W'(1)
                                                : words_left_reg;
    assign hit        = advance && (phase_reg == PH_PAYLOAD) && chan_match;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (in_word_reg == SYNC_WORD)
                        phase_next = PH_HEADER;
                end
                PH_HEADER:
                begin
                    phase_next = in_word_reg[WORD_W-1] ? PH_HUNT : PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    phase_next = len_ok ? PH_PAYLOAD : PH_HUNT;
                end
                PH_PAYLOAD:
                begin
                    if (words_dec == '0)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // payload word counter
    always_comb
    begin
        words_left_next = words_left_reg;
        if (advance)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    words_left_next = len_ok ? in_word_reg[WL_W+1:2] : '0;
                end
                PH_PAYLOAD:
                begin
                    words_left_next = words_dec;
                end
                default:
                begin
                    words_left_next = words_left_reg;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_word_reg <= s_tdata;
    end

    // parser state and channel id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            words_left_reg <= '0;
            chan_id_reg    <= CHAN_ID_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            if (cfg_valid && cfg_ready)
                chan_id_reg <= cfg_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
            out_sample_reg <= in_word_reg[SAMPLE_W-1:0];
    end

`ifndef NO_ASSERTIONS
    // payload phase always has words pending
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (words_left_reg != '0))
        else $error("payload phase with no words left");

    // counter idle outside payload
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PAYLOAD) |-> (words_left_reg == '0))
        else $error("words pending outside payload phase");

    // a free result slot only fills from a matching payload word
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        (out_free && !hit) |=> !m_tvalid)
        else $error("sample produced without a matching payload word");

    // each payload word consumes one count
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (phase_reg == PH_PAYLOAD))
        |=> (words_left_reg == $past(words_left_reg) - WL_W'(1)))
        else $error("payload counter did not step");
`endif

endmodule : adc_frame_channel_extractor

`default_nettype wire

// ----- dv/tb.sv -----
module tb;
    import adcfce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] FRAME_BYTES_MAX  = 32'd1500;
    localparam int          SETTLE_CYCLES    = 6;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT      = 200000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [WORD_W-1:0]          s_tdata = '0;     // [31:0] stream_word
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_tdata;          // [23:0] sample
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CHAN_W-1:0]          cfg_data = '0;    // [7:0] channel_id

    // words waiting to be driven and samples waiting to come out
    logic [WORD_W-1:0]   stream_words [$];
    logic [SAMPLE_W-1:0] expected_samples [$];

    // local copy of the frame parser state and the channel register
    phase_t            parse_phase = PH_HUNT;
    logic [8:0]        payload_left = '0;
    logic [CHAN_W-1:0] active_channel = CHAN_ID_RESET;

    int words_queued = 0;
    int words_accepted = 0;
    int error_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    adc_frame_channel_extractor #(
        .MAX_FRAME_BYTES (FRAME_BYTES_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // one parser step per accepted word, queueing the sample it gives out
    function automatic void advance_frame_parser(input logic [WORD_W-1:0] w);
        case (parse_phase)
            PH_HUNT:
            begin
                if (w == SYNC_WORD)
                    parse_phase = PH_HEADER;
            end
            PH_HEADER:
            begin
                parse_phase = w[WORD_W-1] ? PH_HUNT : PH_LENGTH;
            end
            PH_LENGTH:
            begin
                if (w > FRAME_BYTES_MAX || (w >> 2) == 0)
                begin
                    payload_left = '0;
                    parse_phase  = PH_HUNT;
                end
                else
                begin
                    payload_left = w[10:2];
                    parse_phase  = PH_PAYLOAD;
                end
            end
            default:
            begin
                if (w[WORD_W-1 -: CHAN_W] == active_channel)
                    expected_samples.push_back(w[SAMPLE_W-1:0]);
                if (payload_left != 0)
                    payload_left = payload_left - 1'b1;
                if (payload_left == 0)
                    parse_phase = PH_HUNT;
            end
        endcase
    endfunction

    // input side: accept, predict, then offer the next word or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                advance_frame_parser(s_tdata);
                words_accepted += 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (stream_words.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stream_words.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output side ready: long hold-off on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // sample checker
    always @(posedge clk)
    begin : sample_check
        logic [SAMPLE_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                error_count += 1;
                if (error_count <= 10)
                    $display("unexpected sample %0d", m_tdata);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata !== want)
                begin
                    error_count += 1;
                    if (error_count <= 10)
                        $display("sample mismatch: expected %0d, got %0d",
                                 $signed(want), m_tdata);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count += 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_word(input logic [WORD_W-1:0] w);
        stream_words.push_back(w);
        words_queued += 1;
    endtask

    task automatic push_frame(input logic [WORD_W-1:0] header,
                              input logic [WORD_W-1:0] length_bytes,
                              input int payload_words, input int match_pct);
        logic [CHAN_W-1:0] tag;
        push_word(SYNC_WORD);
        push_word(header);
        push_word(length_bytes);
        for (int i = 0; i < payload_words; i++)
        begin
            tag = ($urandom_range(99) < match_pct) ? active_channel : CHAN_W'($urandom);
            push_word({tag, SAMPLE_W'($urandom)});
        end
    endtask

    // mostly well-formed frames of short length, some broken frames and noise
    task automatic push_random_traffic(input int word_budget, input int match_pct);
        int first;
        int pick;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] good_header;
        first = words_queued;
        while (words_queued - first < word_budget)
        begin
            pick = $urandom_range(99);
            good_header = $urandom & 32'h7FFF_FFFF;
            if (pick < 85)
            begin
                case ($urandom_range(39))
                    0:       len = FRAME_BYTES_MAX;
                    1:       len = $urandom_range(400, 65);
                    default: len = $urandom_range(64, 4);
                endcase
                push_frame(good_header, len, len >> 2, match_pct);
            end
            else if (pick < 89)
                push_frame($urandom | 32'h8000_0000, $urandom_range(64, 4),
                           $urandom_range(3), match_pct);
            else if (pick < 93)
            begin
                len = $urandom_range(1) ? $urandom_range(65535, 1501)
                                        : ($urandom | 32'h0001_0000);
                push_frame(good_header, len, $urandom_range(3), match_pct);
            end
            else if (pick < 96)
                push_frame(good_header, $urandom_range(3), $urandom_range(2), match_pct);
            else
                repeat ($urandom_range(4, 1)) push_word($urandom);
        end
    endtask

    // wait until every word is taken and every sample has come out
    task automatic wait_drained();
        do
            @(posedge clk);
        while (words_accepted != words_queued || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_channel(input logic [CHAN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_channel = value;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames with the reset channel
        push_word(SYNC_WORD); push_word(32'h8000_0000);           // header top bit drops frame
        push_word(SYNC_WORD); push_word(SYNC_WORD);               // all-ones header, not a sync
        push_word(32'h0000_0008); push_word(32'hEA12_3456);       // still hunting
        push_word(SYNC_WORD); push_word(32'h7FFF_FFFF);
        push_word(32'h0000_05DD); push_word(32'hEA00_0001);       // length just over the limit
        push_word(SYNC_WORD); push_word(32'h0000_0000);
        push_word(32'h0000_0003); push_word(32'hEA7F_FFFF);       // length below one word
        push_word(SYNC_WORD); push_word(32'h0000_0000);
        push_word(32'h0000_000B);                                 // odd length, two words
        push_word(32'hEA80_0000); push_word(SYNC_WORD);           // sync inside payload
        push_word(SYNC_WORD); push_word(32'h0000_0001); push_word(32'h0000_000C);
        push_word(32'hEAFF_FFFF); push_word(32'hEA00_0000); push_word(32'hEA7F_FFFF);
        wait_drained();

        // full-size frame with a long receiver hold-off
        write_channel(8'h00);
        push_frame(32'h0000_0000, FRAME_BYTES_MAX, FRAME_BYTES_MAX >> 2, 80);
        hold_requests += 1;
        push_random_traffic(100, 70);
        wait_drained();

        // all-ones channel, so a sync word in payload matches
        write_channel(8'hFF);
        set_idling(50, 0);
        push_word(SYNC_WORD); push_word(32'h0000_0000); push_word(32'h0000_0008);
        push_word(SYNC_WORD); push_word(32'hFF80_0000);
        push_random_traffic(110, 50);
        wait_drained();

        write_channel(CHAN_W'($urandom));
        set_idling(0, 50);
        push_random_traffic(110, 50);
        wait_drained();

        write_channel(CHAN_ID_RESET);
        set_idling(7, 7);
        push_random_traffic(110, 50);
        wait_drained();

        write_channel(CHAN_W'($urandom));
        set_idling(0, 0);
        push_random_traffic(110, 60);
        wait_drained();

        write_channel(CHAN_W'($urandom));
        set_idling(50, 50);
        push_random_traffic(110, 50);
        wait_drained();

        if (error_count == 0 && expected_samples.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/adcfce_pkg.sv
design/adc_frame_channel_extractor.sv
dv/tb.sv
